// ===== rtl/core/sphc_pkg.sv =====
// Package for the stepper pulse generator with homing.
// Holds command and phase codes, stream field layout and shared constants.
// No dependencies; used by the top level and its checker.
package sphc_pkg;

    // Base full steps of the motor per revolution; the go-to limit is this
    // value shifted left by the microstep mode.
    localparam int FULL_STEPS_PER_REV = 200;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_USED_W  = 41;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [15:0] UNBOUNDED   = 16'hFFFF;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam logic [8:0]  ELAPSED_MAX = 9'h1FF;

    localparam logic [8:0] HALF_PERIOD_RESET = 9'd5;
    localparam logic [1:0] MICROSTEP_RESET   = 2'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP   = 1'd1;

    // Homing phase codes
    localparam logic [2:0] PH_HOMING_LO = 3'd0;
    localparam logic [2:0] PH_HOMING_HI = 3'd1;
    localparam logic [2:0] PH_HOMED_LO  = 3'd2;
    localparam logic [2:0] PH_HOMED_HI  = 3'd3;
    localparam logic [2:0] PH_NEVER     = 3'd4;

    // Move direction codes
    localparam logic [1:0] DIR_LOW    = 2'd0;
    localparam logic [1:0] DIR_TOGGLE = 2'd2;

    // Sleep action codes
    localparam logic [1:0] SLEEP_WAKE   = 2'd0;
    localparam logic [1:0] SLEEP_SLEEP  = 2'd1;
    localparam logic [1:0] SLEEP_TOGGLE = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_MOVE  = 3'd1,
        OP_HOME  = 3'd2,
        OP_GOTO  = 3'd3,
        OP_SLEEP = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        limit_level;
        logic [1:0]  sleep_action;
        logic [15:0] target_position;
        logic [15:0] step_count;
        logic [1:0]  direction;
    } cmd_t;

endpackage

// ===== rtl/core/stepper_pulse_homing_controller_top.sv =====
// Stepper step/dir pulse generator with limit-switch homing, top level.
// Depends on sphc_pkg.

// Each command item yields exactly one result item: a snapshot of the pins and
// counters after the command. An item is first held in the input register
// and moves to the result register once that register is free, and its result
// then waits on the master side; one item per cycle is sustained while the
// output is not stalled. The result register and the input register form two
// stages, so a new item is taken while a finished result waits on the master
// side. The command state (step/dir pins, position, remaining count, elapsed
// ms, homing phase) updates as an item moves from the input register to the
// result register. Configuration writes take effect on the next item; the user
// must make them only while the block is idle, as the block has no check for it.
module stepper_pulse_homing_controller_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // direction[1:0], step_count[17:2], target_position[33:18],
    // sleep_action[35:34], limit_level[36], zero fill[39:37]
    input  logic [sphc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode[2:0]
    input  logic [sphc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // step_level[0], dir_level[1], mode_pin_one[2], mode_pin_two[3],
    // awake_level[4], position[20:5], remaining[36:21], homing_phase[39:37],
    // limit_event[40], zero fill[47:41]
    output logic [sphc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [sphc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sphc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [8:0]  half_period_reg;
    logic [1:0]  mode_reg;

    logic            in_valid_reg;
    sphc_pkg::cmd_t  in_item_reg;
    logic            out_valid_reg;
    logic [sphc_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [sphc_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic        step_reg, step_next;
    logic        dir_reg, dir_next;
    logic        awake_reg, awake_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [8:0]  elapsed_reg, elapsed_next;
    logic [2:0]  phase_reg, phase_next;
    logic        home_side_reg, home_side_next;
    logic        limit_last_reg, limit_last_next;
    logic        event_next;

    logic out_free;
    logic in_move;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_move       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [15:0] rem_t;
        logic [15:0] pos_t;
        logic [2:0]  ph_t;
        logic [8:0]  el_t;
        logic        homed_t;
        logic [15:0] limit_val;
        logic [15:0] tgt_c;

        step_next       = step_reg;
        dir_next        = dir_reg;
        awake_next      = awake_reg;
        position_next   = position_reg;
        remaining_next  = remaining_reg;
        elapsed_next    = elapsed_reg;
        phase_next      = phase_reg;
        home_side_next  = home_side_reg;
        limit_last_next = limit_last_reg;
        event_next      = 1'b0;

        rem_t     = remaining_reg;
        pos_t     = position_reg;
        ph_t      = phase_reg;
        el_t      = elapsed_reg;
        homed_t   = 1'b0;
        limit_val = 16'(sphc_pkg::FULL_STEPS_PER_REV) << mode_reg;
        tgt_c     = (in_item_reg.target_position > limit_val) ? limit_val
                                                              : in_item_reg.target_position;

        case (sphc_pkg::opcode_t'(in_item_reg.opcode))
            sphc_pkg::OP_TICK:
            begin
                // falling limit edge ends a homing run
                if (!in_item_reg.limit_level && limit_last_reg)
                begin
                    event_next = 1'b1;
                    if (phase_reg == sphc_pkg::PH_HOMING_LO ||
                        phase_reg == sphc_pkg::PH_HOMING_HI)
                    begin
                        rem_t = 16'd0;
                        pos_t = 16'd0;
                        ph_t  = home_side_reg ? sphc_pkg::PH_HOMED_HI
                                              : sphc_pkg::PH_HOMED_LO;
                    end
                end
                limit_last_next = in_item_reg.limit_level;
                if (el_t != sphc_pkg::ELAPSED_MAX)
                    el_t = el_t + 9'd1;
                homed_t = (ph_t == sphc_pkg::PH_HOMED_LO) || (ph_t == sphc_pkg::PH_HOMED_HI);
                if (rem_t != 16'd0 && el_t >= half_period_reg)
                begin
                    el_t      = 9'd0;
                    step_next = !step_reg;
                    // falling step edge consumes a step
                    if (step_reg)
                    begin
                        if (rem_t != sphc_pkg::UNBOUNDED)
                            rem_t = rem_t - 16'd1;
                        if (homed_t)
                        begin
                            if (dir_reg)
                            begin
                                if (pos_t != sphc_pkg::POS_MAX)
                                    pos_t = pos_t + 16'd1;
                            end
                            else if (pos_t != 16'd0)
                            begin
                                pos_t = pos_t - 16'd1;
                            end
                        end
                    end
                end
                remaining_next = rem_t;
                position_next  = pos_t;
                phase_next     = ph_t;
                elapsed_next   = el_t;
            end
            sphc_pkg::OP_MOVE:
            begin
                if (in_item_reg.direction == sphc_pkg::DIR_TOGGLE)
                    dir_next = !dir_reg;
                else
                    dir_next = (in_item_reg.direction != sphc_pkg::DIR_LOW);
                remaining_next = in_item_reg.step_count;
            end
            sphc_pkg::OP_HOME:
            begin
                home_side_next = (in_item_reg.direction != sphc_pkg::DIR_LOW);
                phase_next     = home_side_next ? sphc_pkg::PH_HOMING_HI
                                                : sphc_pkg::PH_HOMING_LO;
                dir_next       = home_side_next;
                remaining_next = sphc_pkg::UNBOUNDED;
            end
            sphc_pkg::OP_GOTO:
            begin
                if (phase_reg == sphc_pkg::PH_HOMED_LO || phase_reg == sphc_pkg::PH_HOMED_HI)
                begin
                    if (tgt_c > position_reg)
                    begin
                        dir_next       = 1'b1;
                        remaining_next = tgt_c - position_reg;
                    end
                    else if (tgt_c < position_reg)
                    begin
                        dir_next       = 1'b0;
                        remaining_next = position_reg - tgt_c;
                    end
                end
            end
            sphc_pkg::OP_SLEEP:
            begin
                case (in_item_reg.sleep_action)
                    sphc_pkg::SLEEP_WAKE:   awake_next = 1'b1;
                    sphc_pkg::SLEEP_SLEEP:  awake_next = 1'b0;
                    sphc_pkg::SLEEP_TOGGLE: awake_next = !awake_reg;
                    default:                awake_next = awake_reg;
                endcase
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase

        out_data_next = {
            {(sphc_pkg::OUT_TDATA_W - sphc_pkg::OUT_USED_W){1'b0}},
            event_next, phase_next, remaining_next, position_next,
            awake_next, mode_reg[1], mode_reg[0], dir_next, step_next
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= sphc_pkg::HALF_PERIOD_RESET;
            mode_reg        <= sphc_pkg::MICROSTEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sphc_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                sphc_pkg::CFG_MICROSTEP:   mode_reg        <= cfg_data[1:0];
                default:                   mode_reg        <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= 1'b0;
            dir_reg        <= 1'b0;
            awake_reg      <= 1'b1;
            position_reg   <= 16'd0;
            remaining_reg  <= 16'd0;
            elapsed_reg    <= sphc_pkg::ELAPSED_MAX;
            phase_reg      <= sphc_pkg::PH_NEVER;
            home_side_reg  <= 1'b0;
            limit_last_reg <= 1'b1;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (in_move)
                in_valid_reg <= 1'b0;

            if (in_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (in_move)
            begin
                step_reg       <= step_next;
                dir_reg        <= dir_next;
                awake_reg      <= awake_next;
                position_reg   <= position_next;
                remaining_reg  <= remaining_next;
                elapsed_reg    <= elapsed_next;
                phase_reg      <= phase_next;
                home_side_reg  <= home_side_next;
                limit_last_reg <= limit_last_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.opcode          <= s_axis_tuser;
            in_item_reg.direction       <= s_axis_tdata[1:0];
            in_item_reg.step_count      <= s_axis_tdata[17:2];
            in_item_reg.target_position <= s_axis_tdata[33:18];
            in_item_reg.sleep_action    <= s_axis_tdata[35:34];
            in_item_reg.limit_level     <= s_axis_tdata[36];
        end
        if (in_move)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/sphc_checker.sv =====
// Port-level checker for the stepper pulse generator top level, with bind.
// Depends on sphc_pkg and stepper_pulse_homing_controller_top.
module sphc_assertions (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sphc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with nothing waiting at the output the input side is never blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a result that rises on an idle output matches an item taken through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching item");

    // fill bits above the result fields stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[sphc_pkg::OUT_TDATA_W-1:sphc_pkg::OUT_USED_W] == '0)
        else $error("nonzero fill bits in result");

endmodule

bind stepper_pulse_homing_controller_top sphc_assertions u_sphc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/sphc_checker.sv =====
// Result checker for the stepper pulse generator with homing.
// Watches the command, result and config ports, predicts each snapshot and compares.
// Depends on sphc_pkg.
module sphc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // direction[1:0], step_count[17:2], target_position[33:18],
    // sleep_action[35:34], limit_level[36], zero fill[39:37]
    input  logic [sphc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [sphc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // step_level[0], dir_level[1], mode_pin_one[2], mode_pin_two[3],
    // awake_level[4], position[20:5], remaining[36:21], homing_phase[39:37],
    // limit_event[40], zero fill[47:41]
    input  logic [sphc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [sphc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sphc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);
    import sphc_pkg::*;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic        mode_pin_one;
        logic        mode_pin_two;
        logic        awake_level;
        logic [15:0] position;
        logic [15:0] remaining;
        logic [2:0]  homing_phase;
        logic        limit_event;
    } snapshot_t;

    // configuration copy
    logic [8:0]  half_period;
    logic [1:0]  ustep_mode;

    // motor state copy
    logic        step_pin;
    logic        dir_pin;
    logic        awake_pin;
    logic [15:0] pos_count;
    logic [15:0] steps_left;
    logic [8:0]  ms_since_toggle;
    logic [2:0]  phase;
    logic        home_hi;
    logic        limit_prev;

    snapshot_t   expected_snapshots[$];
    snapshot_t   predicted;
    snapshot_t   oldest;
    snapshot_t   observed;
    cmd_t        incoming;

    function automatic logic homed();
        return phase == PH_HOMED_LO || phase == PH_HOMED_HI;
    endfunction

    task automatic tick_motor(input logic level, output logic edge_seen);
        edge_seen = 1'b0;
        if (!level && limit_prev)
        begin
            edge_seen = 1'b1;
            if (phase == PH_HOMING_LO || phase == PH_HOMING_HI)
            begin
                steps_left = '0;
                pos_count  = '0;
                phase      = home_hi ? PH_HOMED_HI : PH_HOMED_LO;
            end
        end
        limit_prev = level;
        if (ms_since_toggle < ELAPSED_MAX)
            ms_since_toggle++;
        if (steps_left != 0 && ms_since_toggle >= half_period)
        begin
            ms_since_toggle = '0;
            step_pin = ~step_pin;
            // falling step edge completes one step
            if (!step_pin)
            begin
                if (steps_left != UNBOUNDED)
                    steps_left--;
                if (homed())
                begin
                    if (dir_pin)
                    begin
                        if (pos_count < POS_MAX)
                            pos_count++;
                    end
                    else if (pos_count > 0)
                        pos_count--;
                end
            end
        end
    endtask

    task automatic advance_motor(input cmd_t c, output snapshot_t s);
        logic        edge_seen;
        logic [16:0] pos_limit;
        logic [16:0] goal;
        edge_seen = 1'b0;
        case (c.opcode)
            OP_TICK:
                tick_motor(c.limit_level, edge_seen);
            OP_MOVE:
            begin
                if (c.direction == DIR_TOGGLE)
                    dir_pin = ~dir_pin;
                else
                    dir_pin = c.direction != DIR_LOW;
                steps_left = c.step_count;
            end
            OP_HOME:
            begin
                home_hi    = c.direction != DIR_LOW;
                phase      = home_hi ? PH_HOMING_HI : PH_HOMING_LO;
                dir_pin    = home_hi;
                steps_left = UNBOUNDED;
            end
            OP_GOTO:
            begin
                if (homed())
                begin
                    pos_limit = 17'(FULL_STEPS_PER_REV) << ustep_mode;
                    goal = {1'b0, c.target_position};
                    if (goal > pos_limit)
                        goal = pos_limit;
                    if (goal > {1'b0, pos_count})
                    begin
                        dir_pin    = 1'b1;
                        steps_left = 16'(goal - {1'b0, pos_count});
                    end
                    else if (goal < {1'b0, pos_count})
                    begin
                        dir_pin    = 1'b0;
                        steps_left = 16'({1'b0, pos_count} - goal);
                    end
                end
            end
            OP_SLEEP:
            begin
                case (c.sleep_action)
                    SLEEP_WAKE:   awake_pin = 1'b1;
                    SLEEP_SLEEP:  awake_pin = 1'b0;
                    SLEEP_TOGGLE: awake_pin = ~awake_pin;
                    default:      ;
                endcase
            end
            default:
                ;
        endcase
        s.step_level   = step_pin;
        s.dir_level    = dir_pin;
        s.mode_pin_one = ustep_mode[0];
        s.mode_pin_two = ustep_mode[1];
        s.awake_level  = awake_pin;
        s.position     = pos_count;
        s.remaining    = steps_left;
        s.homing_phase = phase;
        s.limit_event  = edge_seen;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period     = HALF_PERIOD_RESET;
            ustep_mode      = MICROSTEP_RESET;
            step_pin        = 1'b0;
            dir_pin         = 1'b0;
            awake_pin       = 1'b1;
            pos_count       = '0;
            steps_left      = '0;
            ms_since_toggle = ELAPSED_MAX;
            phase           = PH_NEVER;
            home_hi         = 1'b0;
            limit_prev      = 1'b1;
            expected_snapshots.delete();
            fail_count      = 0;
            pending        <= 0;
        end
        else
        begin
            // compare before predicting, so a result never meets its own item
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_snapshots.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result expected none actual %h", $time, m_axis_tdata);
                end
                else
                begin
                    oldest = expected_snapshots.pop_front();
                    observed.step_level   = m_axis_tdata[0];
                    observed.dir_level    = m_axis_tdata[1];
                    observed.mode_pin_one = m_axis_tdata[2];
                    observed.mode_pin_two = m_axis_tdata[3];
                    observed.awake_level  = m_axis_tdata[4];
                    observed.position     = m_axis_tdata[20:5];
                    observed.remaining    = m_axis_tdata[36:21];
                    observed.homing_phase = m_axis_tdata[39:37];
                    observed.limit_event  = m_axis_tdata[40];
                    check_field("step_level", 16'(oldest.step_level),
                                16'(observed.step_level));
                    check_field("dir_level", 16'(oldest.dir_level),
                                16'(observed.dir_level));
                    check_field("mode_pin_one", 16'(oldest.mode_pin_one),
                                16'(observed.mode_pin_one));
                    check_field("mode_pin_two", 16'(oldest.mode_pin_two),
                                16'(observed.mode_pin_two));
                    check_field("awake_level", 16'(oldest.awake_level),
                                16'(observed.awake_level));
                    check_field("position", oldest.position, observed.position);
                    check_field("remaining", oldest.remaining, observed.remaining);
                    check_field("homing_phase", 16'(oldest.homing_phase),
                                16'(observed.homing_phase));
                    check_field("limit_event", 16'(oldest.limit_event),
                                16'(observed.limit_event));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HALF_PERIOD: half_period = cfg_data;
                    CFG_MICROSTEP:   ustep_mode  = cfg_data[1:0];
                    default:         ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                incoming = {s_axis_tuser, s_axis_tdata[36:0]};
                advance_motor(incoming, predicted);
                expected_snapshots.push_back(predicted);
            end
            pending <= expected_snapshots.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the stepper pulse generator testbench: clock, reset, command stimulus,
// config phases, result back-pressure, watchdog and verdict.
// Depends on sphc_pkg, stepper_pulse_homing_controller_top and sphc_checker.
module tb_top;
    import sphc_pkg::*;

    localparam int PHASE_ITEMS    = 130;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TARGET_SPAN    = 1700;

    localparam logic [1:0] DIR_HIGH     = 2'd1;
    localparam logic [1:0] DIR_UNUSED   = 2'd3;
    localparam logic [1:0] SLEEP_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     pending;
    int                     idle_cycles;
    logic                   calm;

    stepper_pulse_homing_controller_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sphc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic int input_gap();
        if (calm || $urandom_range(0, 99) < 55)
            return 0;
        return gap_len();
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [1:0] dir,
                                      input logic [15:0] steps, input logic [15:0] goal,
                                      input logic [1:0] sleep_act, input logic level);
        cmd_t c;
        c.opcode          = op;
        c.direction       = dir;
        c.step_count      = steps;
        c.target_position = goal;
        c.sleep_action    = sleep_act;
        c.limit_level     = level;
        return c;
    endfunction

    function automatic cmd_t tick_cmd(input logic level);
        return make_cmd(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), level);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   r;
        c = make_cmd(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            c.opcode = OP_TICK;
            c.limit_level = $urandom_range(0, 99) >= 8;
        end
        else if (r < 67)
            c.opcode = OP_MOVE;
        else if (r < 73)
            c.opcode = OP_HOME;
        else if (r < 85)
            c.opcode = OP_GOTO;
        else if (r < 91)
            c.opcode = OP_SLEEP;
        else
            c.opcode = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 40)
            c.step_count = 16'($urandom_range(1, 12));
        else if (r < 55)
            c.step_count = '0;
        else if (r < 70)
            c.step_count = UNBOUNDED;
        r = $urandom_range(0, 99);
        if (r < 60)
            c.target_position = 16'($urandom_range(0, TARGET_SPAN));
        else if (r < 75)
            c.target_position = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        // toggle and the unused code are less common than plain low/high
        if ($urandom_range(0, 99) < 70)
            c.direction = 2'($urandom_range(0, 1));
        return c;
    endfunction

    // Leaves tvalid high; caller decides whether the next item follows at once.
    task automatic send_cmd(input cmd_t c);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.opcode;
        s_axis_tdata  <= {3'b000, c.limit_level, c.sleep_action, c.target_position,
                          c.step_count, c.direction};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic issue(input cmd_t c);
        int gap;
        send_cmd(c);
        gap = input_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic homing_run(output int count);
        int k;
        issue(make_cmd(OP_HOME, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))));
        k = $urandom_range(1, 5);
        repeat (k) issue(tick_cmd(1'b1));
        issue(tick_cmd(1'b0));
        issue(tick_cmd(1'b1));
        count = k + 3;
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 99) < 30)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int                    n;
        int                    run_len;
        logic [CFG_DATA_W-1:0] half_settings[7];
        logic [1:0]            mode_settings[7];

        half_settings = '{9'd1, 9'd2, 9'd3, 9'd1, 9'd500, 9'd4, 9'd0};
        mode_settings = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        calm          = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_HALF_PERIOD;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero half period toggles on every tick; eighth mode gives the widest limit
        write_cfg(CFG_HALF_PERIOD, 9'd0);
        write_cfg(CFG_MICROSTEP, 9'd3);
        cfg_we <= 1'b0;
        @(posedge clk);

        issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_GOTO, DIR_LOW, 16'd0, 16'd100, SLEEP_WAKE, 1'b1));  // not homed
        issue(make_cmd(OP_MOVE, DIR_UNUSED, 16'd1, 16'd0, SLEEP_WAKE, 1'b1));
        repeat (2) issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        // limit edge with no homing run: event only
        issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b0));
        issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_HOME, DIR_TOGGLE, 16'hFFFF, 16'hFFFF, SLEEP_UNUSED, 1'b0));
        issue(make_cmd(OP_TICK, DIR_LOW, 16'hFFFF, 16'hFFFF, SLEEP_WAKE, 1'b0));
        issue(make_cmd(OP_GOTO, DIR_LOW, 16'd0, 16'hFFFF, SLEEP_WAKE, 1'b1)); // clamped
        repeat (2) issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_MOVE, DIR_LOW, 16'd2, 16'd0, SLEEP_WAKE, 1'b1));
        // second step down hits the floor
        repeat (4) issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_GOTO, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));   // already there
        issue(make_cmd(OP_SLEEP, DIR_LOW, 16'd0, 16'd0, SLEEP_SLEEP, 1'b1));
        issue(make_cmd(OP_SLEEP, DIR_LOW, 16'd0, 16'd0, SLEEP_UNUSED, 1'b1));
        issue(make_cmd(OP_SLEEP, DIR_LOW, 16'd0, 16'd0, SLEEP_TOGGLE, 1'b1));
        issue(make_cmd(OP_SLEEP, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        for (int op = OP_SLEEP + 1; op < 8; op++)
            issue(make_cmd(3'(op), DIR_UNUSED, 16'hFFFF, 16'hFFFF, SLEEP_UNUSED, 1'b0));
        issue(make_cmd(OP_MOVE, DIR_TOGGLE, UNBOUNDED, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_TICK, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_HOME, DIR_LOW, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));
        issue(make_cmd(OP_MOVE, DIR_HIGH, 16'd0, 16'd0, SLEEP_WAKE, 1'b1));

        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            write_cfg(CFG_HALF_PERIOD, half_settings[ph]);
            write_cfg(CFG_MICROSTEP, CFG_DATA_W'(mode_settings[ph]));
            cfg_we <= 1'b0;
            @(posedge clk);
            calm = (ph == 2);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    homing_run(run_len);
                    n += run_len;
                end
                else
                begin
                    issue(random_cmd());
                    n++;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sphc_pkg.sv
rtl/core/stepper_pulse_homing_controller_top.sv
rtl/core/sphc_checker.sv
test/sphc_checker.sv
test/tb_top.sv
